### rtl/core/hwt_pkg.sv
// Shared types, codes and defaults for the hashed timing wheel.
`timescale 1ns / 1ps

package hwt_pkg;

   // Timer pool addressing: ids are 6 bits, links carry a null flag in bit 6.
   localparam int ID_W        = 6;
   localparam int LINK_W      = 7;
   localparam int TMR_DEPTH   = 64;
   localparam int DELAY_W     = 32;
   localparam int EVENT_W     = 16;
   localparam int STATUS_W    = 3;
   localparam logic [LINK_W-1:0] LINK_NULL = 7'h40;

   // Defaults for the top-level parameters.
   localparam int DEF_WHEEL_SLOTS   = 64;
   localparam int DEF_TICK_INTERVAL = 1;
   localparam int DEF_POOL_SIZE     = 64;

   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_REARM  = 2'd1,
      OP_DELETE = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_SET_OK    = 3'd0,
      RS_POOL_FULL = 3'd1,
      RS_DONE      = 3'd2,
      RS_EXPIRED   = 3'd3,
      RS_NO_EXPIRY = 3'd4,
      RS_INACTIVE  = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [ID_W-1:0]    entry_id;
      logic [DELAY_W-1:0] delay;
      logic [EVENT_W-1:0] event_tag;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     result_id;
      logic [EVENT_W-1:0]  result_event;
      logic                last;
   } rsp_type;

endpackage

### rtl/core/hashed_timing_wheel.sv
// Hashed timing wheel over a fixed timer pool, driven by a small sequencer.
//
//  Channel  Direction  Ports                          Carries
//  req      in         req_valid req_ready req_data   one request: set, rearm, delete, tick
//  rsp      out        rsp_valid rsp_ready rsp_data   one result, several for an expiring tick
//
// After reset the slot heads are cleared in turn; req_ready stays low meanwhile.
// One request at a time. Set scans for the lowest free timer, runs the shared divider twice
// and links the timer in at the head of its slot; a full pool ends the scan with a pool-full result.
// Rearm unlinks the timer and places it again like set, delete only unlinks it, an inactive
// id goes straight to its result, and tick walks the list of the current slot timer by timer.
// A held result stalls the sequencer only when a further result must be written.
`timescale 1ns / 1ps

module hashed_timing_wheel
   import hwt_pkg::*;
#(
   parameter int WHEEL_SLOTS   = DEF_WHEEL_SLOTS,
   parameter int TICK_INTERVAL = DEF_TICK_INTERVAL,
   parameter int POOL_SIZE     = DEF_POOL_SIZE
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
   localparam int SCAN_W = ID_W + 1;
   localparam logic [DELAY_W-1:0] TICK_RECIP =
      DELAY_W'(64'(32'hFFFF_FFFF) / 64'(TICK_INTERVAL));
   localparam logic [DELAY_W-1:0] SLOT_RECIP =
      DELAY_W'(64'(32'hFFFF_FFFF) / 64'(WHEEL_SLOTS));

   typedef enum logic [16:0] {
      S_CLEAR     = 17'h00001,
      S_IDLE      = 17'h00002,
      S_SCAN      = 17'h00004,
      S_UL_RD     = 17'h00008,
      S_UL_WR     = 17'h00010,
      S_DIV1_GO   = 17'h00020,
      S_DIV1_WAIT = 17'h00040,
      S_DIV2_WAIT = 17'h00080,
      S_PL_RD     = 17'h00100,
      S_PL_WR     = 17'h00200,
      S_PL_FIX    = 17'h00400,
      S_TK_HEAD   = 17'h00800,
      S_TK_LOAD   = 17'h01000,
      S_TK_RD     = 17'h02000,
      S_TK_EVAL   = 17'h04000,
      S_TK_END    = 17'h08000,
      S_RESP      = 17'h10000
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff;
   logic [LINK_W-1:0]   lnk_ff;
   logic [LINK_W-1:0]   h_ff;
   logic [SCAN_W-1:0]   scan_ff;
   logic [SLOT_W-1:0]   clr_ff;
   logic [SLOT_W-1:0]   wheel_pos_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [DELAY_W-1:0]  rounds_ff;
   logic [TMR_DEPTH-1:0] in_use_ff;
   rsp_type             resp_ff;
   rsp_type             pend_ff;
   logic                pend_valid_ff;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;

   // Memories and their registered read data.
   logic [LINK_W-1:0]  head_mem   [WHEEL_SLOTS];
   logic [LINK_W-1:0]  next_mem   [TMR_DEPTH];
   logic [LINK_W-1:0]  prev_mem   [TMR_DEPTH];
   logic [DELAY_W-1:0] rounds_mem [TMR_DEPTH];
   logic [SLOT_W-1:0]  home_mem   [TMR_DEPTH];
   logic [EVENT_W-1:0] event_mem  [TMR_DEPTH];
   logic [LINK_W-1:0]  head_rd_ff;
   logic [LINK_W-1:0]  next_rd_ff;
   logic [LINK_W-1:0]  prev_rd_ff;
   logic [DELAY_W-1:0] rounds_rd_ff;
   logic [SLOT_W-1:0]  home_rd_ff;
   logic [EVENT_W-1:0] event_rd_ff;

   logic [ID_W-1:0]    tmr;
   logic [SLOT_W-1:0]  head_ra;
   logic               head_we, next_we, prev_we, rounds_we, home_we, event_we;
   logic [SLOT_W-1:0]  head_wa;
   logic [ID_W-1:0]    next_wa, prev_wa;
   logic [LINK_W-1:0]  head_wd, next_wd, prev_wd;
   logic [DELAY_W-1:0] rounds_wd;

   logic               accept, out_free, push;
   rsp_type            push_data;
   logic               id_ok, expire, tk_go, unlink_en;
   logic               div_start, div_done;
   logic [DELAY_W-1:0] div_dividend, div_divisor, div_recip, div_quo, div_rem;
   logic [DELAY_W-1:0] ticks;
   logic [SLOT_W:0]    slot_sum;
   logic [SLOT_W-1:0]  slot_new;
   logic [SLOT_W-1:0]  cur_next;

   assign tmr      = lnk_ff[ID_W-1:0];
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign id_ok    = ({1'b0, req_data.entry_id} < SCAN_W'(POOL_SIZE)) &&
                     in_use_ff[req_data.entry_id];
   assign expire   = (rounds_rd_ff == '0);
   assign tk_go    = !pend_valid_ff || out_free;
   assign unlink_en = (state_ff == S_UL_WR) || ((state_ff == S_TK_EVAL) && expire && tk_go);

   // Shared divider: delay by the tick interval, then ticks by the wheel size.
   assign ticks        = (div_quo == '0) ? DELAY_W'(1) : div_quo;
   assign div_start    = (state_ff == S_DIV1_GO) || ((state_ff == S_DIV1_WAIT) && div_done);
   assign div_dividend = (state_ff == S_DIV1_GO) ? req_ff.delay : ticks;
   assign div_divisor  = (state_ff == S_DIV1_GO) ? DELAY_W'(TICK_INTERVAL)
                                                 : DELAY_W'(WHEEL_SLOTS);
   assign div_recip    = (state_ff == S_DIV1_GO) ? TICK_RECIP : SLOT_RECIP;

   hwt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .recip     (div_recip),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Home slot of a placed timer, wrapped once into the wheel.
   assign slot_sum = {1'b0, wheel_pos_ff} + {1'b0, div_rem[SLOT_W-1:0]};
   assign slot_new = (slot_sum >= (SLOT_W+1)'(WHEEL_SLOTS)) ?
                     SLOT_W'(slot_sum - (SLOT_W+1)'(WHEEL_SLOTS)) : slot_sum[SLOT_W-1:0];
   assign cur_next = (wheel_pos_ff == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : wheel_pos_ff + 1'b1;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == SLOT_W'(WHEEL_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  OP_SET:  state_in = S_SCAN;
                  OP_TICK: state_in = S_TK_HEAD;
                  default: state_in = id_ok ? S_UL_RD : S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_ff == SCAN_W'(POOL_SIZE)) state_in = S_RESP;
            else if (!in_use_ff[scan_ff[ID_W-1:0]]) state_in = S_DIV1_GO;
         end
         S_UL_RD:     state_in = S_UL_WR;
         S_UL_WR:     state_in = (req_ff.opcode == OP_REARM) ? S_DIV1_GO : S_RESP;
         S_DIV1_GO:   state_in = S_DIV1_WAIT;
         S_DIV1_WAIT: if (div_done) state_in = S_DIV2_WAIT;
         S_DIV2_WAIT: if (div_done) state_in = S_PL_RD;
         S_PL_RD:     state_in = S_PL_WR;
         S_PL_WR:     state_in = S_PL_FIX;
         S_PL_FIX:    state_in = S_RESP;
         S_TK_HEAD:   state_in = S_TK_LOAD;
         S_TK_LOAD:   state_in = S_TK_RD;
         S_TK_RD:     state_in = lnk_ff[ID_W] ? S_TK_END : S_TK_EVAL;
         S_TK_EVAL: begin
            if (!expire || tk_go) state_in = S_TK_RD;
         end
         S_TK_END:    if (out_free) state_in = S_IDLE;
         S_RESP:      if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Result push into the output register.
   always_comb begin
      push      = 1'b0;
      push_data = resp_ff;
      case (state_ff)
         S_RESP: begin
            push = out_free;
         end
         S_TK_EVAL: begin
            push      = expire && pend_valid_ff && out_free;
            push_data = pend_ff;
         end
         S_TK_END: begin
            push = out_free;
            if (pend_valid_ff) begin
               push_data      = pend_ff;
               push_data.last = 1'b1;
            end else begin
               push_data = '{status: RS_NO_EXPIRY, result_id: '0, result_event: '0, last: 1'b1};
            end
         end
         default: push = 1'b0;
      endcase
   end

   // Memory write ports.
   always_comb begin
      head_we   = 1'b0;
      head_wa   = home_rd_ff;
      head_wd   = next_rd_ff;
      next_we   = 1'b0;
      next_wa   = prev_rd_ff[ID_W-1:0];
      next_wd   = next_rd_ff;
      prev_we   = 1'b0;
      prev_wa   = next_rd_ff[ID_W-1:0];
      prev_wd   = prev_rd_ff;
      rounds_we = 1'b0;
      rounds_wd = rounds_rd_ff - 1'b1;
      home_we   = (state_ff == S_PL_WR);
      event_we  = (state_ff == S_SCAN) && (scan_ff != SCAN_W'(POOL_SIZE)) &&
                  !in_use_ff[scan_ff[ID_W-1:0]];
      if (state_ff == S_CLEAR) begin
         head_we = 1'b1;
         head_wa = clr_ff;
         head_wd = LINK_NULL;
      end else if (unlink_en) begin
         // Close the gap that the timer leaves in its slot list.
         head_we = prev_rd_ff[ID_W];
         next_we = !prev_rd_ff[ID_W];
         prev_we = !next_rd_ff[ID_W];
      end else if (state_ff == S_PL_WR) begin
         // Link the timer at the head of its new slot.
         head_we   = 1'b1;
         head_wa   = slot_ff;
         head_wd   = lnk_ff;
         next_we   = 1'b1;
         next_wa   = tmr;
         next_wd   = head_rd_ff;
         prev_we   = 1'b1;
         prev_wa   = tmr;
         prev_wd   = LINK_NULL;
         rounds_we = 1'b1;
         rounds_wd = rounds_ff;
      end else if (state_ff == S_PL_FIX) begin
         prev_we = !h_ff[ID_W];
         prev_wa = h_ff[ID_W-1:0];
         prev_wd = lnk_ff;
      end else if ((state_ff == S_TK_EVAL) && !expire) begin
         rounds_we = 1'b1;
      end
   end

   assign head_ra = (state_ff == S_PL_RD) ? slot_ff : wheel_pos_ff;

   // Slot head memory.
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      head_rd_ff <= head_mem[head_ra];
   end

   // Per-timer memories, all read at the timer under work.
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      next_rd_ff <= next_mem[tmr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      prev_rd_ff <= prev_mem[tmr];
   end

   always_ff @(posedge clock) begin
      if (rounds_we) rounds_mem[tmr] <= rounds_wd;
      rounds_rd_ff <= rounds_mem[tmr];
   end

   always_ff @(posedge clock) begin
      if (home_we) home_mem[tmr] <= slot_ff;
      home_rd_ff <= home_mem[tmr];
   end

   always_ff @(posedge clock) begin
      if (event_we) event_mem[scan_ff[ID_W-1:0]] <= req_ff.event_tag;
      event_rd_ff <= event_mem[tmr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         wheel_pos_ff  <= '0;
         in_use_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (event_we) in_use_ff[scan_ff[ID_W-1:0]] <= 1'b1;
         if ((state_ff == S_UL_WR) && (req_ff.opcode == OP_DELETE)) in_use_ff[tmr] <= 1'b0;
         if ((state_ff == S_TK_EVAL) && expire && tk_go) begin
            in_use_ff[tmr] <= 1'b0;
            pend_valid_ff  <= 1'b1;
         end
         if ((state_ff == S_TK_END) && out_free) begin
            pend_valid_ff <= 1'b0;
            wheel_pos_ff  <= cur_next;
         end
         if (push) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      if (push) rsp_ff <= push_data;
      case (state_ff)
         S_IDLE: begin
            req_ff  <= req_data;
            scan_ff <= '0;
            lnk_ff  <= {1'b0, req_data.entry_id};
            resp_ff <= '{status: RS_INACTIVE, result_id: req_data.entry_id,
                         result_event: '0, last: 1'b1};
         end
         S_SCAN: begin
            scan_ff <= scan_ff + 1'b1;
            lnk_ff  <= {1'b0, scan_ff[ID_W-1:0]};
            resp_ff <= '{status: RS_POOL_FULL, result_id: '0, result_event: '0, last: 1'b1};
         end
         S_UL_WR: begin
            resp_ff <= '{status: RS_DONE, result_id: tmr, result_event: '0, last: 1'b1};
         end
         S_DIV2_WAIT: begin
            rounds_ff <= div_quo;
            slot_ff   <= slot_new;
         end
         S_PL_WR: begin
            h_ff <= head_rd_ff;
         end
         S_PL_FIX: begin
            resp_ff <= '{status: (req_ff.opcode == OP_SET) ? RS_SET_OK : RS_DONE,
                         result_id: tmr, result_event: '0, last: 1'b1};
         end
         S_TK_LOAD: begin
            lnk_ff <= head_rd_ff;
         end
         S_TK_EVAL: begin
            if (!expire || tk_go) lnk_ff <= next_rd_ff;
            if (expire && tk_go) begin
               pend_ff <= '{status: RS_EXPIRED, result_id: tmr,
                            result_event: event_rd_ff, last: 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result is only written into a free output register.
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result written over a pending result");

   // A buffered expiry only lives inside a tick walk.
   a_pend_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == S_TK_RD || state_ff == S_TK_EVAL ||
                         state_ff == S_TK_END))
      else $error("expiry buffered outside a tick");

   // The divider reports completion only while the sequencer waits on it.
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV1_WAIT || state_ff == S_DIV2_WAIT))
      else $error("divider finished while nobody waited");

   // One request at a time: taking a request drops ready next cycle.
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second request taken while busy");

endmodule

### rtl/core/hwt_div.sv
// Division by a constant through a reciprocal multiply, a back-multiply and one correction.
`timescale 1ns / 1ps

module hwt_div
   import hwt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DELAY_W-1:0] dividend,
   input  logic [DELAY_W-1:0] divisor,
   input  logic [DELAY_W-1:0] recip,
   output logic               done,
   output logic [DELAY_W-1:0] quotient,
   output logic [DELAY_W-1:0] remainder
);

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_MULQ = 4'b0010,
      D_MULR = 4'b0100,
      D_FIX  = 4'b1000
   } div_state_type;

   div_state_type        state_ff;
   logic                 done_ff;
   logic [DELAY_W-1:0]   x_ff;
   logic [DELAY_W-1:0]   d_ff;
   logic [DELAY_W-1:0]   m_ff;
   logic [DELAY_W-1:0]   quo_ff;
   logic [DELAY_W-1:0]   rem_ff;
   logic [DELAY_W-1:0]   mul_a;
   logic [DELAY_W-1:0]   mul_b;
   logic [2*DELAY_W-1:0] product;

   // One multiplier serves both the reciprocal step and the back-multiply.
   // The reciprocal is floor((2^32 - 1) / divisor), so the first estimate is
   // never above the true quotient and at most one below it.
   assign mul_a   = (state_ff == D_MULQ) ? x_ff : quo_ff;
   assign mul_b   = (state_ff == D_MULQ) ? m_ff : d_ff;
   assign product = {{DELAY_W{1'b0}}, mul_a} * {{DELAY_W{1'b0}}, mul_b};

   // Control: the working states MULQ, MULR and FIX in turn, then a one-cycle done.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            state_ff <= D_MULQ;
         end else begin
            case (state_ff)
               D_MULQ:  state_ff <= D_MULR;
               D_MULR:  state_ff <= D_FIX;
               D_FIX: begin
                  state_ff <= D_IDLE;
                  done_ff  <= 1'b1;
               end
               default: state_ff <= D_IDLE;
            endcase
         end
      end
   end

   // Datapath: estimate, remainder of the estimate, then a single fix-up.
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= dividend;
         d_ff <= divisor;
         m_ff <= recip;
      end else begin
         case (state_ff)
            D_MULQ: quo_ff <= product[2*DELAY_W-1:DELAY_W];
            D_MULR: rem_ff <= x_ff - product[DELAY_W-1:0];
            D_FIX: begin
               if (rem_ff >= d_ff) begin
                  rem_ff <= rem_ff - d_ff;
                  quo_ff <= quo_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### tb/hashed_timing_wheel_tb.sv
// Self-checking testbench for the hashed timing wheel: directed and random timer requests.
`timescale 1ns / 1ps

module hashed_timing_wheel_tb;
   import hwt_pkg::*;

   localparam int WHEEL_SLOTS   = DEF_WHEEL_SLOTS;
   localparam int TICK_INTERVAL = DEF_TICK_INTERVAL;
   localparam int POOL_SIZE     = DEF_POOL_SIZE;
   localparam int CYCLE_LIMIT   = 1500000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   hashed_timing_wheel #(
      .WHEEL_SLOTS(WHEEL_SLOTS),
      .TICK_INTERVAL(TICK_INTERVAL),
      .POOL_SIZE(POOL_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the wheel state.
   logic [LINK_W-1:0] wheel_head [WHEEL_SLOTS];
   logic [LINK_W-1:0] fwd_link [TMR_DEPTH];
   logic [LINK_W-1:0] back_link [TMR_DEPTH];
   logic [31:0]       rounds [TMR_DEPTH];
   logic [31:0]       home [TMR_DEPTH];
   logic [EVENT_W-1:0] tag_of [TMR_DEPTH];
   bit                live [TMR_DEPTH];
   int unsigned       wheel_pos;

   rsp_type expected_rsps [$];
   int     mismatches = 0;
   int     cycles = 0;
   bit     hold_off = 1'b0;

   task automatic clear_shadow();
      for (int i = 0; i < WHEEL_SLOTS; i++) wheel_head[i] = LINK_NULL;
      for (int i = 0; i < TMR_DEPTH; i++) begin
         fwd_link[i] = '0;
         back_link[i] = '0;
         rounds[i] = '0;
         home[i] = '0;
         tag_of[i] = '0;
         live[i] = 1'b0;
      end
      wheel_pos = 0;
   endtask

   function automatic void detach(int t);
      logic [LINK_W-1:0] p, n;
      p = back_link[t];
      n = fwd_link[t];
      if (p == LINK_NULL) wheel_head[home[t] % WHEEL_SLOTS] = n;
      else fwd_link[p[ID_W-1:0]] = n;
      if (n != LINK_NULL) back_link[n[ID_W-1:0]] = p;
   endfunction

   function automatic void attach(int t, logic [31:0] dly);
      logic [31:0] ticks, s;
      logic [LINK_W-1:0] h;
      ticks = dly / TICK_INTERVAL;
      if (ticks == 0) ticks = 1;
      rounds[t] = ticks / WHEEL_SLOTS;
      s = (wheel_pos + (ticks % WHEEL_SLOTS)) % WHEEL_SLOTS;
      home[t] = s;
      h = wheel_head[s];
      fwd_link[t] = h;
      back_link[t] = LINK_NULL;
      if (h != LINK_NULL) back_link[h[ID_W-1:0]] = LINK_W'(t);
      wheel_head[s] = LINK_W'(t);
   endfunction

   function automatic rsp_type make_rsp(status_type st, int id, logic [15:0] ev, bit lst);
      rsp_type r;
      r.status = st;
      r.result_id = ID_W'(id);
      r.result_event = ev;
      r.last = lst;
      return r;
   endfunction

   // Work out the results of one request and update the shadow wheel.
   function automatic void predict_timer_op(req_type rq);
      int n;
      int guard;
      int t;
      logic [LINK_W-1:0] cur, nx;
      rsp_type r;
      n = 0;
      case (op_type'(rq.opcode))
         OP_SET: begin
            for (int i = 0; i < POOL_SIZE; i++) begin
               if (!live[i]) begin
                  live[i] = 1'b1;
                  tag_of[i] = rq.event_tag;
                  attach(i, rq.delay);
                  expected_rsps.push_back(make_rsp(RS_SET_OK, i, '0, 1'b1));
                  return;
               end
            end
            expected_rsps.push_back(make_rsp(RS_POOL_FULL, 0, '0, 1'b1));
         end
         OP_REARM, OP_DELETE: begin
            t = rq.entry_id;
            if (t >= POOL_SIZE || !live[t]) begin
               expected_rsps.push_back(make_rsp(RS_INACTIVE, t, '0, 1'b1));
            end else begin
               detach(t);
               if (op_type'(rq.opcode) == OP_REARM) attach(t, rq.delay);
               else live[t] = 1'b0;
               expected_rsps.push_back(make_rsp(RS_DONE, t, '0, 1'b1));
            end
         end
         default: begin
            guard = 0;
            cur = wheel_head[wheel_pos % WHEEL_SLOTS];
            while (cur != LINK_NULL && guard < POOL_SIZE) begin
               t = cur[ID_W-1:0];
               nx = fwd_link[t];
               guard++;
               if (rounds[t] > 0) begin
                  rounds[t] = rounds[t] - 1;
               end else begin
                  expected_rsps.push_back(make_rsp(RS_EXPIRED, t, tag_of[t], 1'b0));
                  n++;
                  detach(t);
                  live[t] = 1'b0;
               end
               cur = nx;
            end
            wheel_pos = (wheel_pos + 1) % WHEEL_SLOTS;
            if (n == 0) begin
               expected_rsps.push_back(make_rsp(RS_NO_EXPIRY, 0, '0, 1'b1));
            end else begin
               r = expected_rsps.pop_back();
               r.last = 1'b1;
               expected_rsps.push_back(r);
            end
         end
      endcase
   endfunction

   function automatic int short_or_long_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Offer one request and hold it until accepted. Valid is dropped only
   // when a gap follows, so back-to-back requests keep it high.
   task automatic send_request(op_type op, int id, logic [31:0] dly, logic [15:0] ev,
                               bit gaps = 1'b1);
      req_type rq;
      int gap;
      rq.opcode = op;
      rq.entry_id = ID_W'(id);
      rq.delay = dly;
      rq.event_tag = ev;
      gap = gaps ? short_or_long_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_timer_op(rq);
   endtask

   function automatic logic [31:0] random_delay();
      case ($urandom_range(0, 5))
         0: return 32'(0);
         1: return $urandom;
         2: return $urandom_range(64, 300);
         default: return $urandom_range(1, 63);
      endcase
   endfunction

   // Result receiver with random stalls and a long hold-off on demand.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== exp_rsp.status
                || rsp_data.result_id !== exp_rsp.result_id
                || rsp_data.result_event !== exp_rsp.result_event
                || rsp_data.last !== exp_rsp.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", exp_rsp, rsp_data);
            end
         end
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("hashed_timing_wheel_tb failed");
         $finish;
      end
   end

   // Operations on an empty wheel: a tick, a delete and a rearm on an idle pool.
   task automatic test_empty_wheel();
      send_request(OP_TICK, 0, '0, '0);
      send_request(OP_DELETE, 0, '0, '0);
      send_request(OP_REARM, 63, 32'hFFFF_FFFF, 16'hFFFF);
   endtask

   // Extremes of delay and event, a rearm and a repeated delete, then expiry through ticks.
   task automatic test_set_and_expire();
      send_request(OP_SET, 0, 32'd0, 16'h0000);
      send_request(OP_SET, 63, 32'd1, 16'hFFFF);
      send_request(OP_SET, 0, 32'hFFFF_FFFF, 16'hA5A5);
      send_request(OP_SET, 0, 32'd64, 16'h5A5A);
      send_request(OP_SET, 0, 32'd2, 16'h1234);
      send_request(OP_REARM, 4, 32'd1, 16'h0);
      send_request(OP_DELETE, 2, '0, '0);
      send_request(OP_DELETE, 2, '0, '0);
      repeat (4) send_request(OP_TICK, 0, '0, '0);
      send_request(OP_REARM, 1, 32'd63, '0);
   endtask

   // Fill the pool, hit pool full, then expire many timers at once.
   task automatic test_pool_full();
      for (int i = 0; i < POOL_SIZE + 1; i++) send_request(OP_SET, 0, 32'd1, 16'(i), 1'b0);
      for (int i = 0; i < 66; i++) send_request(OP_TICK, 0, '0, '0, 1'b0);
   endtask

   // Random mix weighted towards live timers and ticks.
   task automatic test_random_mix();
      int op;
      int id;
      for (int k = 0; k < 110; k++) begin
         op = $urandom_range(0, 9);
         id = $urandom_range(0, 63);
         if ($urandom_range(0, 3) != 0) begin
            for (int j = 0; j < POOL_SIZE; j++)
               if (live[(id + j) % POOL_SIZE]) begin
                  id = (id + j) % POOL_SIZE;
                  break;
               end
         end
         if (op < 3) send_request(OP_SET, 0, random_delay(), 16'($urandom));
         else if (op < 5) send_request(OP_REARM, id, random_delay(), 16'($urandom));
         else if (op < 6) send_request(OP_DELETE, id, '0, 16'($urandom));
         else send_request(OP_TICK, id, $urandom, 16'($urandom));
      end
   endtask

   // Receiver holds off while requests keep coming, so the block backs up.
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 6; i++) send_request(OP_SET, 0, 32'd1, 16'(i + 100), 1'b0);
            for (int i = 0; i < 6; i++) send_request(OP_TICK, 0, '0, '0, 1'b0);
         end
      join
   endtask

   initial begin
      clear_shadow();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_wheel();
      test_set_and_expire();
      test_pool_full();
      test_backpressure();
      test_random_mix();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("hashed_timing_wheel_tb passed");
      end else begin
         $display("hashed_timing_wheel_tb failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/hwt_pkg.sv
rtl/core/hwt_div.sv
rtl/core/hashed_timing_wheel.sv
tb/hashed_timing_wheel_tb.sv
